// ===== src/modular_fraction_fermat_inverse_macros.svh =====
// Assertion macros shared by the modular fraction design files.
`ifndef MODULAR_FRACTION_FERMAT_INVERSE_MACROS_SVH
`define MODULAR_FRACTION_FERMAT_INVERSE_MACROS_SVH

`ifndef ASSERT_OFF

// Check a condition in the same cycle as its trigger.
`define MFFI_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("mffi assertion failed");

// Check a condition in the cycle after its trigger.
`define MFFI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("mffi assertion failed");

`else

`define MFFI_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define MFFI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== src/mffi_pkg.sv =====
// Shared types and constants of the modular fraction pipeline.
package mffi_pkg;

	typedef logic [29:0] residue_t;

	localparam residue_t FIELD_PRIME = 30'd998244353;

	// Fixed Fermat exponent, scanned one bit per cell, least significant first.
	localparam residue_t EXPONENT = FIELD_PRIME - 30'd2;

	// Barrett constant floor(2^60 / prime); fits in 31 bits.
	localparam logic [30:0] BARRETT_MU = 31'((64'd1 << 60) / 64'(FIELD_PRIME));

	localparam logic [31:0] PRIME_W  = {2'b00, FIELD_PRIME};
	localparam logic [31:0] PRIME_X2 = {1'b0, FIELD_PRIME, 1'b0};

	localparam int CELLS     = 30;
	localparam int MM_STAGES = 5;
	localparam int LATENCY   = CELLS * MM_STAGES;

endpackage

// ===== src/modular_fraction_fermat_inverse.sv =====
// Top level: p / q modulo 998244353 through a chain of exponent-bit cells.
//
//  channel  | transfer when          | payload
//  ---------+------------------------+-------------------------------
//  command  | start && !busy         | numerator[29:0], denominator[29:0]
//  result   | done (one cycle)       | quotient[29:0]
//
// One item enters per cycle. The chain is 30 cells, one per exponent bit,
// each built from five-stage modular multipliers (30x30 product, Barrett
// estimate, estimate times prime, subtract, final correction).
// Reset clears only the valid bits of the chain; payload registers hold junk.
// busy stays low: the receiver takes every result, so the chain never stalls.
`include "modular_fraction_fermat_inverse_macros.svh"

module modular_fraction_fermat_inverse (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  mffi_pkg::residue_t numerator,
	input  mffi_pkg::residue_t denominator,
	output logic               done,
	output mffi_pkg::residue_t quotient
);
	import mffi_pkg::*;

	// Chain links: index i feeds cell i, index CELLS leaves the chain.
	logic     link_valid [0:CELLS];
	residue_t link_acc   [0:CELLS];
	residue_t link_base  [0:CELLS];

	// The chain never holds off a command.
	assign busy = 1'b0;

	// Cell 0 sees the raw operands; its multiply reduces an unreduced
	// numerator, and the squaring reduces the denominator.
	assign link_valid[0] = start && !busy;
	assign link_acc[0]   = numerator;
	assign link_base[0]  = denominator;

	for (genvar i = 0; i < CELLS; i++) begin : g_cell
		mffi_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.exp_bit   (EXPONENT[i]),
			.in_valid  (link_valid[i]),
			.in_acc    (link_acc[i]),
			.in_base   (link_base[i]),
			.out_valid (link_valid[i+1]),
			.out_acc   (link_acc[i+1]),
			.out_base  (link_base[i+1])
		);
	end

	// The last squaring is never consumed; drop it.
	assign done     = link_valid[CELLS];
	assign quotient = link_acc[CELLS];

	`MFFI_ASSERT_SAME(a_done_follows_start, clk, arst_n, done, $past(start && !busy, LATENCY))
	`MFFI_ASSERT_SAME(a_quotient_reduced, clk, arst_n, done, quotient < FIELD_PRIME)
	`MFFI_ASSERT_SAME(a_zero_denominator, clk, arst_n,
		done && $past(denominator == '0, LATENCY), quotient == '0)

endmodule

// ===== src/mffi_mulmod.sv =====
// Five-stage modular multiplier with Barrett reduction by the field prime.
module mffi_mulmod (
	input  logic              clk,
	input  mffi_pkg::residue_t a,
	input  mffi_pkg::residue_t b,
	output mffi_pkg::residue_t prod_mod
);
	import mffi_pkg::*;

	logic [59:0] prod;
	logic [61:0] est;
	logic [60:0] qp_full;
	logic [31:0] fixed;

	logic [59:0] prod_s1;
	logic [30:0] quot_s2;
	logic [31:0] xlo_s2;
	logic [31:0] qp_s3;
	logic [31:0] xlo_s3;
	logic [31:0] rem_s4;
	residue_t    res_s5;

	assign prod    = a * b;
	assign est     = prod_s1[59:29] * BARRETT_MU;
	assign qp_full = quot_s2 * FIELD_PRIME;

	// Remainder lies below three times the prime: at most two subtractions.
	always_comb begin
		if (rem_s4 >= PRIME_X2) begin
			fixed = rem_s4 - PRIME_X2;
		end else if (rem_s4 >= PRIME_W) begin
			fixed = rem_s4 - PRIME_W;
		end else begin
			fixed = rem_s4;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= prod;
		quot_s2 <= est[61:31];
		xlo_s2  <= prod_s1[31:0];
		qp_s3   <= qp_full[31:0];
		xlo_s3  <= xlo_s2;
		rem_s4  <= xlo_s3 - qp_s3;
		res_s5  <= fixed[29:0];
	end

	assign prod_mod = res_s5;

endmodule

// ===== src/mffi_cell.sv =====
// One exponent bit of square-and-multiply: conditional multiply plus squaring.
`include "modular_fraction_fermat_inverse_macros.svh"

module mffi_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               exp_bit,
	input  logic               in_valid,
	input  mffi_pkg::residue_t in_acc,
	input  mffi_pkg::residue_t in_base,
	output logic               out_valid,
	output mffi_pkg::residue_t out_acc,
	output mffi_pkg::residue_t out_base
);
	import mffi_pkg::*;

	residue_t mul_res;
	residue_t acc_s1, acc_s2, acc_s3, acc_s4, acc_s5;
	logic [MM_STAGES-1:0] valid_q;

	mffi_mulmod u_mul (
		.clk      (clk),
		.a        (in_acc),
		.b        (in_base),
		.prod_mod (mul_res)
	);

	mffi_mulmod u_sqr (
		.clk      (clk),
		.a        (in_base),
		.b        (in_base),
		.prod_mod (out_base)
	);

	// Carry the accumulator alongside the multiplier for a zero bit.
	always_ff @(posedge clk) begin
		acc_s1 <= in_acc;
		acc_s2 <= acc_s1;
		acc_s3 <= acc_s2;
		acc_s4 <= acc_s3;
		acc_s5 <= acc_s4;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			valid_q <= {valid_q[MM_STAGES-2:0], in_valid};
		end
	end

	assign out_valid = valid_q[MM_STAGES-1];
	assign out_acc   = exp_bit ? mul_res : acc_s5;

	`MFFI_ASSERT_SAME(a_valid_delay, clk, arst_n, out_valid, $past(in_valid, MM_STAGES))
	`MFFI_ASSERT_SAME(a_base_reduced, clk, arst_n, out_valid, out_base < FIELD_PRIME)
	`MFFI_ASSERT_SAME(a_acc_reduced, clk, arst_n, out_valid && exp_bit, out_acc < FIELD_PRIME)

endmodule
